>>> design/pcc_pkg.sv
package pcc_pkg;

	localparam int unsigned BTN_W  = 5;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned KIND_W = 3;

	localparam logic [1:0] FUNC_BUTTON = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_MOTION = 2'd2;

	localparam logic [BTN_W-1:0] BTN_NONE      = 5'd0;
	localparam logic [BTN_W-1:0] BTN_PRIMARY   = 5'd1;
	localparam logic [BTN_W-1:0] BTN_MIDDLE    = 5'd2;
	localparam logic [BTN_W-1:0] BTN_SECONDARY = 5'd3;

	localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;

	localparam logic [KIND_W-1:0] KIND_SINGLE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MIDDLE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RIGHT   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DOUBLE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd5;

	localparam logic [0:0] REG_DOUBLE_CLICK = 1'd0;
	localparam logic [0:0] REG_LONG_PRESS   = 1'd1;

	typedef struct packed {
		logic [BTN_W-1:0]  cur_btn;
		logic [CNT_W-1:0]  press_cnt;
		logic [CNT_W-1:0]  rel_cnt;
		logic [TICK_W-1:0] dc_rem;
		logic              dc_act;
		logic [TICK_W-1:0] lp_rem;
		logic              lp_act;
	} cls_state_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [BTN_W-1:0] button_id;
		logic             pressed;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
	} result_t;

	typedef struct packed {
		logic              report;
		logic              clear;
		logic [KIND_W-1:0] kind;
	} flush_t;

	localparam cls_state_t STATE_CLEAR = '0;

	function automatic flush_t do_flush(input cls_state_t s);
		flush_t f;
		f = '0;
		if (s.press_cnt < s.rel_cnt) begin
			f.clear = 1'b1;
		end else if (s.press_cnt == 3'd1 && s.rel_cnt == 3'd1) begin
			f.report = 1'b1;
			f.clear  = 1'b1;
			case (s.cur_btn)
				BTN_PRIMARY:   f.kind = KIND_SINGLE;
				BTN_MIDDLE:    f.kind = KIND_MIDDLE;
				BTN_SECONDARY: f.kind = KIND_RIGHT;
				default:       f.kind = KIND_UNKNOWN;
			endcase
		end else if (s.cur_btn == BTN_PRIMARY && s.press_cnt == 3'd2) begin
			f.report = 1'b1;
			f.clear  = 1'b1;
			f.kind   = KIND_DOUBLE;
		end
		return f;
	endfunction

endpackage

>>> design/pcc_update.sv
module pcc_update
	import pcc_pkg::*;
(
	input  cls_state_t        state,
	input  item_t             item,
	input  logic [TICK_W-1:0] dc_ticks,
	input  logic [TICK_W-1:0] lp_ticks,
	output cls_state_t        state_next,
	output result_t           result
);

	cls_state_t n;
	flush_t     f;
	logic       dc_exp;
	logic       lp_exp;

	always_comb begin
		n      = state;
		f      = '0;
		dc_exp = 1'b0;
		lp_exp = 1'b0;
		result = '0;
		case (item.func)
			FUNC_BUTTON: begin
				if (n.cur_btn != item.button_id) begin
					n.cur_btn   = item.button_id;
					n.press_cnt = '0;
					n.rel_cnt   = '0;
				end
				if (item.pressed) begin
					if (n.press_cnt < COUNT_MAX) begin
						n.press_cnt = n.press_cnt + 3'd1;
					end
					n.dc_act = 1'b0;
					n.dc_rem = '0;
				end else begin
					if (n.rel_cnt < COUNT_MAX) begin
						n.rel_cnt = n.rel_cnt + 3'd1;
					end
				end
				n.lp_act = 1'b0;
				n.lp_rem = '0;
				if (n.cur_btn == BTN_PRIMARY && n.press_cnt == 3'd1) begin
					if (n.rel_cnt == 3'd0) begin
						n.dc_rem = dc_ticks;
						n.dc_act = 1'b1;
						n.lp_rem = lp_ticks;
						n.lp_act = 1'b1;
					end
				end else begin
					f = do_flush(n);
					if (f.clear) begin
						n = STATE_CLEAR;
					end
					result.valid = f.report;
					result.kind  = f.kind;
				end
			end
			FUNC_TICK: begin
				if (n.dc_act) begin
					if (n.dc_rem <= 16'd1) begin
						dc_exp   = 1'b1;
						n.dc_rem = '0;
						n.dc_act = 1'b0;
					end else begin
						n.dc_rem = n.dc_rem - 16'd1;
					end
				end
				if (n.lp_act) begin
					if (n.lp_rem <= 16'd1) begin
						lp_exp   = 1'b1;
						n.lp_rem = '0;
					end else begin
						n.lp_rem = n.lp_rem - 16'd1;
					end
				end
				if (dc_exp) begin
					f = do_flush(n);
				end
				if (f.clear) begin
					n            = STATE_CLEAR;
					result.valid = f.report;
					result.kind  = f.kind;
				end else if (lp_exp && n.lp_act) begin
					n            = STATE_CLEAR;
					result.valid = 1'b1;
					result.kind  = KIND_HOLD;
				end
			end
			FUNC_MOTION: begin
				n = STATE_CLEAR;
			end
			default: begin
				n = state;
			end
		endcase
		state_next = n;
	end

endmodule

>>> design/pointer_click_classifier.sv
// Pointer click classifier.
// Input stream (s_*): one item per handshake. s_tuser carries the item kind
// (0 button event, 1 millisecond tick, 2 motion); s_tdata carries the button
// number and the press flag. Output stream (m_*): one click code per result,
// in m_tdata. Items that report nothing produce no output item.
// Configuration channel (cfg_*): index 0 sets the double-click window, index 1
// the long-press hold time, both in ticks; cfg_ready is always high.
// An accepted item sits in the input register; its click code is registered
// into the output register, raising m_tvalid, once that register is free.
// Throughput: one item per cycle while the receiver does not stall, set by
// the combinational state update between the input and output registers.
// When the receiver stalls, the output register holds its code; the input
// register still drains while the output register is free, and s_tready
// drops only once both are full.
// Reset clears the classifier state, empties both registers and restores the
// default window lengths of 400 and 500 ticks.
module pointer_click_classifier
	import pcc_pkg::*;
#(
	parameter int unsigned DC_TICKS_RESET = 400,
	parameter int unsigned LP_TICKS_RESET = 500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] button_id, [5] pressed, [7:6] zero
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] click_kind, [7:3] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	item_t             item_s1;
	logic              valid_s2;
	logic [KIND_W-1:0] kind_s2;
	cls_state_t        state_q;
	cls_state_t        state_next;
	result_t           result;
	logic [TICK_W-1:0] dc_ticks_q;
	logic [TICK_W-1:0] lp_ticks_q;
	logic              advance;

	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {5'd0, kind_s2};

	pcc_update u_update (
		.state      (state_q),
		.item       (item_s1),
		.dc_ticks   (dc_ticks_q),
		.lp_ticks   (lp_ticks_q),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_ticks_q <= TICK_W'(DC_TICKS_RESET);
			lp_ticks_q <= TICK_W'(LP_TICKS_RESET);
		end else if (cfg_valid && cfg_index[1] == 1'b0) begin
			case (cfg_index[0])
				REG_DOUBLE_CLICK: dc_ticks_q <= cfg_data;
				REG_LONG_PRESS:   lp_ticks_q <= cfg_data;
				default:          dc_ticks_q <= dc_ticks_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func      <= s_tuser;
			item_s1.button_id <= s_tdata[4:0];
			item_s1.pressed   <= s_tdata[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_CLEAR;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && result.valid;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.valid) begin
			kind_s2 <= result.kind;
		end
	end

	a_hold_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && result.valid && result.kind == KIND_HOLD)
		|=> (state_q.cur_btn == BTN_NONE && !state_q.lp_act && !state_q.dc_act))
		else $error("hold report did not clear the classifier");

	a_lp_primary: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.lp_act |-> state_q.cur_btn == BTN_PRIMARY)
		else $error("long-press timer running for a non-primary button");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> (!s_tready && !advance))
		else $error("input taken while both registers are full");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance || !valid_s1) |=> $stable(state_q))
		else $error("classifier state changed without an item");

endmodule

>>> tb/pointer_click_classifier_test.sv
`timescale 1ns / 100ps

module pointer_click_classifier_test;
	import pcc_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [TICK_W-1:0] DC_DEFAULT = 16'd400;
	localparam logic [TICK_W-1:0] LP_DEFAULT = 16'd500;

	class click_scoreboard;
		logic [TICK_W-1:0] dc_len;
		logic [TICK_W-1:0] lp_len;
		logic [BTN_W-1:0]  cur_btn;
		logic [CNT_W-1:0]  presses;
		logic [CNT_W-1:0]  releases;
		logic [TICK_W-1:0] dc_rem;
		logic [TICK_W-1:0] lp_rem;
		bit                dc_on;
		bit                lp_on;
		logic [KIND_W-1:0] clicks_due[$];
		int                mismatches;

		function new();
			dc_len = DC_DEFAULT;
			lp_len = LP_DEFAULT;
			mismatches = 0;
			clear_all();
		endfunction

		function void clear_all();
			cur_btn = BTN_NONE;
			presses = '0;
			releases = '0;
			dc_rem = '0;
			dc_on = 1'b0;
			lp_rem = '0;
			lp_on = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [TICK_W-1:0] val);
			if (idx == REG_DOUBLE_CLICK) begin
				dc_len = val;
			end else if (idx == REG_LONG_PRESS) begin
				lp_len = val;
			end
		endfunction

		function bit run_flush(output logic [KIND_W-1:0] kind);
			kind = KIND_SINGLE;
			if (presses < releases) begin
				clear_all();
				return 1'b0;
			end
			if (presses == 3'd1 && releases == 3'd1) begin
				case (cur_btn)
					BTN_PRIMARY: begin
						kind = KIND_SINGLE;
					end
					BTN_MIDDLE: begin
						kind = KIND_MIDDLE;
					end
					BTN_SECONDARY: begin
						kind = KIND_RIGHT;
					end
					default: begin
						kind = KIND_UNKNOWN;
					end
				endcase
				clear_all();
				return 1'b1;
			end
			if (cur_btn == BTN_PRIMARY && presses == 3'd2) begin
				kind = KIND_DOUBLE;
				clear_all();
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(logic [1:0] func, logic [BTN_W-1:0] btn, logic pr);
			logic [KIND_W-1:0] kind;
			bit dc_exp;
			bit lp_exp;
			dc_exp = 1'b0;
			lp_exp = 1'b0;
			case (func)
				FUNC_BUTTON: begin
					if (cur_btn != btn) begin
						cur_btn = btn;
						presses = '0;
						releases = '0;
					end
					if (pr) begin
						if (presses < COUNT_MAX)
							presses++;
						dc_on = 1'b0;
						dc_rem = '0;
					end else if (releases < COUNT_MAX) begin
						releases++;
					end
					lp_on = 1'b0;
					lp_rem = '0;
					if (cur_btn == BTN_PRIMARY && presses == 3'd1) begin
						if (releases == 3'd0) begin
							dc_rem = dc_len;
							dc_on = 1'b1;
							lp_rem = lp_len;
							lp_on = 1'b1;
						end
					end else if (run_flush(kind)) begin
						clicks_due.push_back(kind);
					end
				end
				FUNC_TICK: begin
					if (dc_on) begin
						if (dc_rem <= 16'd1) begin
							dc_exp = 1'b1;
							dc_rem = '0;
							dc_on = 1'b0;
						end else begin
							dc_rem--;
						end
					end
					if (lp_on) begin
						if (lp_rem <= 16'd1) begin
							lp_exp = 1'b1;
							lp_rem = '0;
						end else begin
							lp_rem--;
						end
					end
					if (dc_exp) begin
						if (run_flush(kind)) begin
							clicks_due.push_back(kind);
							return;
						end
					end
					if (lp_exp && lp_on) begin
						clear_all();
						clicks_due.push_back(KIND_HOLD);
					end
				end
				FUNC_MOTION: begin
					clear_all();
				end
				default: begin
				end
			endcase
		endfunction

		function void check_click(logic [7:0] data);
			logic [7:0] want;
			if (clicks_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected click item: got %0d", data);
				return;
			end
			want = {{(8 - KIND_W){1'b0}}, clicks_due.pop_front()};
			if (data !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("click mismatch: expected %0d, got %0d", want, data);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	click_scoreboard sb;
	bit quiet = 1'b0;
	int stall_left = 0;
	int items_sent = 0;

	pointer_click_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 10);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser, s_tdata[BTN_W-1:0], s_tdata[BTN_W]);
			if (m_tvalid && m_tready)
				sb.check_click(m_tdata);
		end
	end

	function automatic int tick_span(logic [TICK_W-1:0] len);
		int span;
		span = (len == 0) ? 1 : int'(len);
		if (span > 12)
			span = 12;
		return span;
	endfunction

	task automatic send(input logic [1:0] func, input logic [BTN_W-1:0] btn, input logic pr);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {2'b00, pr, btn};
		do @(posedge clk); while (!s_tready);
		if (func != FUNC_UNUSED)
			items_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send(FUNC_TICK, BTN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.clicks_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic new_setting(input logic [15:0] dc, input logic [15:0] lp);
		write_reg(2'(REG_DOUBLE_CLICK), dc);
		write_reg(2'(REG_LONG_PRESS), lp);
	endtask

	task automatic directed_items();
		// single click closed by the double-click window
		send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
		send(FUNC_BUTTON, BTN_PRIMARY, 1'b0);
		send_ticks(2);
		send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
		send(FUNC_BUTTON, BTN_PRIMARY, 1'b0);
		send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
		// hold: window lapses first with nothing to report
		send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
		send_ticks(3);
		send(FUNC_BUTTON, BTN_MIDDLE, 1'b1);
		send(FUNC_BUTTON, BTN_MIDDLE, 1'b0);
		send(FUNC_BUTTON, BTN_SECONDARY, 1'b1);
		send(FUNC_BUTTON, BTN_SECONDARY, 1'b0);
		send(FUNC_BUTTON, 5'd31, 1'b1);
		send(FUNC_BUTTON, 5'd31, 1'b0);
		send(FUNC_BUTTON, BTN_MIDDLE, 1'b0);
		send(FUNC_MOTION, 5'd31, 1'b1);
		send(FUNC_UNUSED, 5'd31, 1'b1);
		// press count saturation
		repeat (8) send(FUNC_BUTTON, BTN_MIDDLE, 1'b1);
		send(FUNC_BUTTON, BTN_MIDDLE, 1'b0);
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		logic [BTN_W-1:0] b;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: begin
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
				send_ticks($urandom_range(0, tick_span(sb.lp_len)));
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b0);
				send_ticks($urandom_range(0, tick_span(sb.dc_len) + 2));
			end
			2: begin
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
				send_ticks($urandom_range(0, 2));
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b0);
				send_ticks($urandom_range(0, tick_span(sb.dc_len)));
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
				if ($urandom_range(0, 1))
					send(FUNC_BUTTON, BTN_PRIMARY, 1'b0);
				send_ticks($urandom_range(0, 3));
			end
			3: begin
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
				send_ticks(tick_span(sb.lp_len) + $urandom_range(0, 3));
			end
			4, 5: begin
				case ($urandom_range(0, 2))
					0: b = BTN_MIDDLE;
					1: b = BTN_SECONDARY;
					default: b = BTN_W'($urandom_range(0, 31));
				endcase
				repeat ($urandom_range(1, 2)) send(FUNC_BUTTON, b, 1'b1);
				send_ticks($urandom_range(0, 2));
				send(FUNC_BUTTON, b, 1'b0);
			end
			6: begin
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
				send_ticks($urandom_range(0, 3));
				send(FUNC_MOTION, BTN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 1))
					send(FUNC_BUTTON, BTN_PRIMARY, 1'b0);
			end
			7: begin
				send(FUNC_BUTTON, BTN_PRIMARY, 1'b1);
				send(FUNC_BUTTON, BTN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
				send(FUNC_BUTTON, BTN_PRIMARY, 1'($urandom_range(0, 1)));
				send_ticks($urandom_range(0, tick_span(sb.dc_len)));
			end
			default: begin
				n = $urandom_range(1, 4);
				repeat (n) send(2'($urandom_range(0, 3)), BTN_W'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			end
		endcase
	endtask

	task automatic run_items(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) random_sequence();
	endtask

	initial begin
		int wait_cycles;
		sb = new();
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_items(60);
		new_setting(16'd2, 16'd3);
		directed_items();
		new_setting(16'd1, 16'd1);
		run_items(210);
		new_setting(16'd65535, 16'd65535);
		run_items(150);
		new_setting(16'd0, 16'd0);
		run_items(210);
		new_setting(16'd4, 16'd4);
		run_items(210);
		new_setting(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
		run_items(210);
		new_setting(16'd65535, 16'd3);
		run_items(120);
		new_setting(16'd3, 16'd6);
		quiet = 1'b1;
		run_items(200);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_cycles = 0;
		while (sb.clicks_due.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (6) @(posedge clk);
		if (sb.mismatches == 0 && sb.clicks_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
